// ===== rtl/core/crp_pkg.sv =====
// Shared widths, item types and saturation helper for the circle/rectangle push-out block.
`timescale 1ns / 1ps
package crp_pkg;

	// coordinate and derived widths
	localparam int CW    = 24;        // signed coordinate
	localparam int RW    = CW - 1;    // unsigned radius / size
	localparam int EW    = CW + 1;    // rectangle edge (left + width)
	localparam int SW    = CW + 2;    // edge plus or minus radius
	localparam int PW    = 2 * RW;    // product of two sizes
	localparam int NUMW  = PW + 1;    // sum of two products
	localparam int QW    = CW;        // root and quotient bits

	// queues
	localparam int MQ_DEPTH = 4;
	localparam int MQ_AW    = 2;
	localparam int OQ_DEPTH = 64;
	localparam int OQ_AW    = 6;
	localparam int OQ_CAP   = OQ_DEPTH + 2;
	localparam int OCC_W    = 7;

	// back pipeline: two product stages, root, numerator, quotient, final
	localparam int BK_LAT = 2 * QW + 4;
	localparam int FLT_W  = 6;

	// item handed from the front to the back
	typedef struct packed {
		logic signed [CW-1:0] fin_x;
		logic signed [CW-1:0] fin_y;
		logic                 hit;
		logic                 calc;
		logic signed [EW-1:0] nx;
		logic signed [EW-1:0] ny;
		logic [RW-1:0]        ax;
		logic [RW-1:0]        ay;
		logic                 neg_x;
		logic                 neg_y;
		logic [RW-1:0]        rad;
	} crp_item_t;

	// one result beat
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 hit;
	} crp_res_t;

	// clamp a wide sum to the coordinate range
	function automatic logic signed [CW-1:0] sat_c(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		hi = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			return hi[CW-1:0];
		end else if (v < lo) begin
			return lo[CW-1:0];
		end
		return v[CW-1:0];
	endfunction

endpackage

// ===== rtl/core/crp_front.sv =====
// Front part: classifies each circle/rectangle beat and queues the work item.
`timescale 1ns / 1ps
module crp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [crp_pkg::CW-1:0] center_x,
	input  logic signed [crp_pkg::CW-1:0] center_y,
	input  logic [crp_pkg::RW-1:0]        circle_radius,
	input  logic signed [crp_pkg::CW-1:0] rect_left,
	input  logic signed [crp_pkg::CW-1:0] rect_top,
	input  logic [crp_pkg::RW-1:0]        rect_width,
	input  logic [crp_pkg::RW-1:0]        rect_height,
	output logic                          item_valid,
	input  logic                          item_ready,
	output crp_pkg::crp_item_t            item
);

	localparam int CW = crp_pkg::CW;
	localparam int RW = crp_pkg::RW;
	localparam int EW = crp_pkg::EW;
	localparam int SW = crp_pkg::SW;
	localparam int MQ_AW_L = crp_pkg::MQ_AW;

	logic signed [EW-1:0] xe, ye, le, te, re, be;
	logic signed [EW-1:0] dl, drt, dt, db, ex, ey, adx, ady, nx, ny;
	logic signed [SW-1:0] rs, pxs, pys, dxs, dys, adxs, adys;
	logic                 in_rect, pick_l, pick_t, use_x, near;
	crp_pkg::crp_item_t   it_c;

	// classification and the closed-form inside push
	always_comb begin
		xe  = {center_x[CW-1], center_x};
		ye  = {center_y[CW-1], center_y};
		le  = {rect_left[CW-1], rect_left};
		te  = {rect_top[CW-1], rect_top};
		re  = le + $signed({2'b00, rect_width});
		be  = te + $signed({2'b00, rect_height});
		rs  = {{(SW-RW){1'b0}}, circle_radius};
		in_rect = (xe >= le) && (xe < re) && (ye >= te) && (ye < be);

		dl     = xe - le;
		drt    = re - xe;
		dt     = ye - te;
		db     = be - ye;
		pick_l = dl < drt;
		pick_t = dt < db;
		ex     = pick_l ? le : re;
		ey     = pick_t ? te : be;
		adx    = pick_l ? dl : drt;
		ady    = pick_t ? dt : db;
		use_x  = adx < ady;
		pxs    = pick_l ? ({ex[EW-1], ex} - rs) : ({ex[EW-1], ex} + rs);
		pys    = pick_t ? ({ey[EW-1], ey} - rs) : ({ey[EW-1], ey} + rs);

		// nearest rectangle point for an outside center
		nx   = (xe < le) ? le : ((xe > re) ? re : xe);
		ny   = (ye < te) ? te : ((ye > be) ? be : ye);
		dxs  = {nx[EW-1], nx} - {xe[EW-1], xe};
		dys  = {ny[EW-1], ny} - {ye[EW-1], ye};
		adxs = dxs[SW-1] ? -dxs : dxs;
		adys = dys[SW-1] ? -dys : dys;
		near = (adxs < rs) && (adys < rs);

		it_c.fin_x = center_x;
		it_c.fin_y = center_y;
		it_c.hit   = in_rect;
		it_c.calc  = !in_rect && near;
		it_c.nx    = nx;
		it_c.ny    = ny;
		it_c.ax    = adxs[RW-1:0];
		it_c.ay    = adys[RW-1:0];
		it_c.neg_x = dxs[SW-1];
		it_c.neg_y = dys[SW-1];
		it_c.rad   = circle_radius;
		if (in_rect) begin
			if (use_x) begin
				if (adx != '0) begin
					it_c.fin_x = crp_pkg::sat_c(pxs);
				end
			end else begin
				if (ady != '0) begin
					it_c.fin_y = crp_pkg::sat_c(pys);
				end
			end
		end
	end

	// short queue toward the back
	crp_pkg::crp_item_t   mq_q [crp_pkg::MQ_DEPTH];
	logic [MQ_AW_L-1:0]   wp_q, rp_q;
	logic [MQ_AW_L:0]     cnt_q;
	logic                 push_ok, pop_ok;

	assign full       = (cnt_q == (MQ_AW_L+1)'(crp_pkg::MQ_DEPTH));
	assign push_ok    = push && !full;
	assign item_valid = (cnt_q != '0);
	assign pop_ok     = item_valid && item_ready;
	assign item       = mq_q[rp_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mq_q[wp_q] <= it_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) wp_q <= wp_q + 1'b1;
			if (pop_ok) rp_q <= rp_q + 1'b1;
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push_ok && pop_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// queue fill never passes its depth
	a_mq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (MQ_AW_L+1)'(crp_pkg::MQ_DEPTH))
		else $error("front queue overfilled");

endmodule

// ===== rtl/core/crp_back.sv =====
// Back part: exact overlap test, square root and push-out division pipeline.
`timescale 1ns / 1ps
module crp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  crp_pkg::crp_item_t          in_item,
	input  logic [crp_pkg::OCC_W-1:0]   occ,
	output logic                        out_valid,
	output crp_pkg::crp_res_t           out_res
);

	localparam int EW   = crp_pkg::EW;
	localparam int SW   = crp_pkg::SW;
	localparam int PW   = crp_pkg::PW;
	localparam int NUMW = crp_pkg::NUMW;
	localparam int QW   = crp_pkg::QW;

	typedef struct packed {
		crp_pkg::crp_item_t it;
		logic               hit;
		logic               mv;
		logic [PW-1:0]      px;
		logic [PW-1:0]      py;
		logic [2*QW-1:0]    rad;
		logic [QW+2:0]      rem;
		logic [QW-1:0]      root;
	} sq_t;

	typedef struct packed {
		crp_pkg::crp_item_t it;
		logic               hit;
		logic               mv;
		logic [QW-1:0]      len;
		logic [QW-1:0]      rmx;
		logic [QW-1:0]      rmy;
		logic [QW-1:0]      lox;
		logic [QW-1:0]      loy;
		logic [QW-1:0]      qx;
		logic [QW-1:0]      qy;
	} dv_t;

	logic                   acc;
	logic [crp_pkg::FLT_W-1:0] flt_q;

	// credit: everything in flight must fit in the result queue
	assign in_ready = ({2'b00, flt_q} + {1'b0, occ}) < 8'(crp_pkg::OQ_CAP);
	assign acc      = in_valid && in_ready;

	// stage 1: squares and radius products
	logic               v_s1;
	crp_pkg::crp_item_t it_s1;
	logic [PW-1:0]      sqx_s1, sqy_s1, sqr_s1, prx_s1, pry_s1;

	always_ff @(posedge clk) begin
		it_s1  <= in_item;
		sqx_s1 <= PW'(in_item.ax) * PW'(in_item.ax);
		sqy_s1 <= PW'(in_item.ay) * PW'(in_item.ay);
		sqr_s1 <= PW'(in_item.rad) * PW'(in_item.rad);
		prx_s1 <= PW'(in_item.ax) * PW'(in_item.rad);
		pry_s1 <= PW'(in_item.ay) * PW'(in_item.rad);
	end

	// stage 2: distance squared and the exact overlap decision
	sq_t             sq_s [QW+1];
	logic [QW:0]     sq_v;
	logic [NUMW-1:0] d2;
	logic            ovl;

	assign d2  = {1'b0, sqx_s1} + {1'b0, sqy_s1};
	assign ovl = {1'b0, sqr_s1} > d2;

	always_ff @(posedge clk) begin
		sq_s[0].it   <= it_s1;
		sq_s[0].hit  <= it_s1.calc ? ovl : it_s1.hit;
		sq_s[0].mv   <= it_s1.calc && ovl && (d2 != '0);
		sq_s[0].px   <= prx_s1;
		sq_s[0].py   <= pry_s1;
		sq_s[0].rad  <= {1'b0, d2};
		sq_s[0].rem  <= '0;
		sq_s[0].root <= '0;
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_sq
		sq_t           nxt;
		logic [QW+2:0] rn, tr;
		logic          ge;
		always_comb begin
			rn       = {sq_s[k].rem[QW:0], sq_s[k].rad[2*QW-1 -: 2]};
			tr       = {1'b0, sq_s[k].root, 2'b01};
			ge       = rn >= tr;
			nxt      = sq_s[k];
			nxt.rem  = ge ? (rn - tr) : rn;
			nxt.root = {sq_s[k].root[QW-2:0], ge};
			nxt.rad  = {sq_s[k].rad[2*QW-3:0], 2'b00};
		end
		always_ff @(posedge clk) begin
			sq_s[k+1] <= nxt;
		end
	end

	// numerator with half-divisor rounding
	dv_t             dv_s [QW+1];
	logic [QW:0]     dv_v;
	logic [QW-1:0]   len;
	logic [NUMW-1:0] numx, numy;

	assign len  = sq_s[QW].root;
	assign numx = {1'b0, sq_s[QW].px} + NUMW'(len >> 1);
	assign numy = {1'b0, sq_s[QW].py} + NUMW'(len >> 1);

	always_ff @(posedge clk) begin
		dv_s[0].it  <= sq_s[QW].it;
		dv_s[0].hit <= sq_s[QW].hit;
		dv_s[0].mv  <= sq_s[QW].mv;
		dv_s[0].len <= len;
		dv_s[0].rmx <= {1'b0, numx[NUMW-1:QW]};
		dv_s[0].rmy <= {1'b0, numy[NUMW-1:QW]};
		dv_s[0].lox <= numx[QW-1:0];
		dv_s[0].loy <= numy[QW-1:0];
		dv_s[0].qx  <= '0;
		dv_s[0].qy  <= '0;
	end

	// restoring division for both axes, one quotient bit per stage
	for (genvar j = 0; j < QW; j++) begin : g_dv
		dv_t         nxt;
		logic [QW:0] tx, ty, lw;
		logic        gx, gy;
		always_comb begin
			lw      = {1'b0, dv_s[j].len};
			tx      = {dv_s[j].rmx, dv_s[j].lox[QW-1]};
			ty      = {dv_s[j].rmy, dv_s[j].loy[QW-1]};
			gx      = tx >= lw;
			gy      = ty >= lw;
			nxt     = dv_s[j];
			nxt.rmx = gx ? QW'(tx - lw) : tx[QW-1:0];
			nxt.rmy = gy ? QW'(ty - lw) : ty[QW-1:0];
			nxt.lox = {dv_s[j].lox[QW-2:0], 1'b0};
			nxt.loy = {dv_s[j].loy[QW-2:0], 1'b0};
			nxt.qx  = {dv_s[j].qx[QW-2:0], gx};
			nxt.qy  = {dv_s[j].qy[QW-2:0], gy};
		end
		always_ff @(posedge clk) begin
			dv_s[j+1] <= nxt;
		end
	end

	// final: move away from the nearest point and saturate
	logic signed [SW-1:0] rxs, rys, nxs, nys, qxs, qys;
	dv_t                  fz;

	always_comb begin
		fz  = dv_s[QW];
		nxs = {fz.it.nx[EW-1], fz.it.nx};
		nys = {fz.it.ny[EW-1], fz.it.ny};
		qxs = {2'b00, fz.qx};
		qys = {2'b00, fz.qy};
		rxs = fz.it.neg_x ? (nxs + qxs) : (nxs - qxs);
		rys = fz.it.neg_y ? (nys + qys) : (nys - qys);
	end

	always_ff @(posedge clk) begin
		out_res.x   <= fz.mv ? crp_pkg::sat_c(rxs) : fz.it.fin_x;
		out_res.y   <= fz.mv ? crp_pkg::sat_c(rys) : fz.it.fin_y;
		out_res.hit <= fz.hit;
	end

	// beat valid bits and the in-flight count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			sq_v      <= '0;
			dv_v      <= '0;
			out_valid <= 1'b0;
			flt_q     <= '0;
		end else begin
			v_s1      <= acc;
			sq_v      <= {sq_v[QW-1:0], v_s1};
			dv_v      <= {dv_v[QW-1:0], sq_v[QW]};
			out_valid <= dv_v[QW];
			if (acc && !out_valid) begin
				flt_q <= flt_q + 1'b1;
			end else if (!acc && out_valid) begin
				flt_q <= flt_q - 1'b1;
			end
		end
	end

	// in-flight count matches pipeline occupancy limits
	a_flt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flt_q <= crp_pkg::FLT_W'(crp_pkg::BK_LAT))
		else $error("back in-flight count too large");

	a_out_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (flt_q != '0))
		else $error("result beat without an item in flight");

endmodule

// ===== rtl/core/crp_outq.sv =====
// Result queue: memory FIFO with a registered read and an output register.
`timescale 1ns / 1ps
module crp_outq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  crp_pkg::crp_res_t         wr_res,
	output logic                      empty,
	input  logic                      pop,
	output crp_pkg::crp_res_t         head,
	output logic [crp_pkg::OCC_W-1:0] occ
);

	localparam int AW = crp_pkg::OQ_AW;

	crp_pkg::crp_res_t mem_q [crp_pkg::OQ_DEPTH];
	crp_pkg::crp_res_t rdat_q, od_q;
	logic [AW-1:0]     wp_q, rp_q;
	logic [AW:0]       mcnt_q;
	logic              pend_q, ov_q;
	logic              pop_ok, pend_mv, issue;

	assign pop_ok  = pop && ov_q;
	assign pend_mv = pend_q && (!ov_q || pop_ok);
	assign issue   = (mcnt_q != '0) && (!pend_q || pend_mv);
	assign empty   = !ov_q;
	assign head    = od_q;
	assign occ     = crp_pkg::OCC_W'(mcnt_q) + crp_pkg::OCC_W'(pend_q)
	               + crp_pkg::OCC_W'(ov_q);

	// storage, registered read and output register
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_res;
		if (issue) rdat_q <= mem_q[rp_q];
		if (pend_mv) od_q <= rdat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			mcnt_q <= '0;
			pend_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (wr_en) wp_q <= wp_q + 1'b1;
			if (issue) rp_q <= rp_q + 1'b1;
			if (wr_en && !issue) begin
				mcnt_q <= mcnt_q + 1'b1;
			end else if (!wr_en && issue) begin
				mcnt_q <= mcnt_q - 1'b1;
			end
			if (issue) begin
				pend_q <= 1'b1;
			end else if (pend_mv) begin
				pend_q <= 1'b0;
			end
			if (pend_mv) begin
				ov_q <= 1'b1;
			end else if (pop_ok) begin
				ov_q <= 1'b0;
			end
		end
	end

	// credit keeps writes out of a full memory
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (mcnt_q != (AW+1)'(crp_pkg::OQ_DEPTH)))
		else $error("result queue written while full");

endmodule

// ===== rtl/core/circle_rect_pushout.sv =====
// Top level of the circle against rectangle push-out block.
`timescale 1ns / 1ps
// Resolves a circle against an axis-aligned rectangle, signed Q15.8 in 24 bits, and
// returns the resolved center with a collided flag. One item is taken every cycle while
// full is low; each item passes the input queue, the back pipeline with its 24-stage
// square root and 24-stage divider, and the result queue. The result queue holds 66
// beats and the back only starts items it has room for, so a stalled reader fills the
// queues and then raises full; results come out in the order their items went in.
module circle_rect_pushout (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [crp_pkg::CW-1:0] center_x,
	input  logic signed [crp_pkg::CW-1:0] center_y,
	input  logic [crp_pkg::RW-1:0]        circle_radius,
	input  logic signed [crp_pkg::CW-1:0] rect_left,
	input  logic signed [crp_pkg::CW-1:0] rect_top,
	input  logic [crp_pkg::RW-1:0]        rect_width,
	input  logic [crp_pkg::RW-1:0]        rect_height,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [crp_pkg::CW-1:0] new_x,
	output logic signed [crp_pkg::CW-1:0] new_y,
	output logic                          collided
);

	logic                      item_valid, item_ready, bk_valid;
	crp_pkg::crp_item_t        item;
	crp_pkg::crp_res_t         bk_res, head;
	logic [crp_pkg::OCC_W-1:0] occ;

	crp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.center_x      (center_x),
		.center_y      (center_y),
		.circle_radius (circle_radius),
		.rect_left     (rect_left),
		.rect_top      (rect_top),
		.rect_width    (rect_width),
		.rect_height   (rect_height),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item)
	);

	crp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (item_ready),
		.in_item   (item),
		.occ       (occ),
		.out_valid (bk_valid),
		.out_res   (bk_res)
	);

	crp_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (bk_valid),
		.wr_res (bk_res),
		.empty  (empty),
		.pop    (pop),
		.head   (head),
		.occ    (occ)
	);

	assign new_x    = head.x;
	assign new_y    = head.y;
	assign collided = head.hit;

endmodule
